// ----- hdl/png_scanline_unfilter_rgb8_macros.svh -----
// Assertion helpers for the scanline unfilter checks.
// The checker scope must provide signals named clock and reset.
`ifndef PNG_SCANLINE_UNFILTER_RGB8_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_RGB8_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define PSU_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psu check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psu check failed");

`endif

// ----- hdl/psu_pkg.sv -----
package psu_pkg;

   // Row storage geometry
   localparam int MAX_WIDTH = 4096;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WID_BITS  = 13;
   localparam int ROW_BITS  = 16;
   localparam int PIX_BITS  = 24;

   // Configuration register indexes
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA_PRESENT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_SIZE     = 2'd2;

   // Filter codes
   localparam logic [2:0] FILT_NONE    = 3'd0;
   localparam logic [2:0] FILT_SUB     = 3'd1;
   localparam logic [2:0] FILT_UP      = 3'd2;
   localparam logic [2:0] FILT_AVERAGE = 3'd3;
   localparam logic [2:0] FILT_PAETH   = 3'd4;

   // Byte position inside a pixel
   localparam logic [1:0] PH_RED   = 2'd0;
   localparam logic [1:0] PH_GREEN = 2'd1;
   localparam logic [1:0] PH_BLUE  = 2'd2;
   localparam logic [1:0] PH_ALPHA = 2'd3;

   // Paeth predictor on one 8-bit channel
   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [9:0] sa;
      logic signed [9:0] sb;
      logic signed [9:0] sc;
      logic signed [9:0] pa;
      logic signed [9:0] pb;
      logic signed [9:0] pc;
      logic [7:0]        pick;
      sa = signed'({2'b00, a});
      sb = signed'({2'b00, b});
      sc = signed'({2'b00, c});
      pa = sb - sc;
      pb = sa - sc;
      pc = sa + sb - (sc <<< 1);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if ((pa <= pb) && (pa <= pc)) pick = a;
      else if (pb <= pc) pick = b;
      else pick = c;
      return pick;
   endfunction

   // Predictor selected by the row's filter code
   function automatic logic [7:0] predict(input logic [2:0] kind, input logic [7:0] a,
                                          input logic [7:0] b, input logic [7:0] c);
      logic [8:0] avg;
      logic [7:0] pred;
      avg = ({1'b0, a} + {1'b0, b}) >> 1;
      case (kind)
         FILT_SUB:     pred = a;
         FILT_UP:      pred = b;
         FILT_AVERAGE: pred = avg[7:0];
         FILT_PAETH:   pred = paeth(a, b, c);
         default:      pred = 8'd0;
      endcase
      return pred;
   endfunction

endpackage

// ----- hdl/psu_ifs.sv -----
// Input byte channel
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

// Reconstructed pixel channel
interface psu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [7:0]                    red;
   logic [7:0]                    green;
   logic [7:0]                    blue;
   logic [psu_pkg::COL_BITS-1:0]  out_column;
   logic [psu_pkg::ROW_BITS-1:0]  out_row;
   logic                          row_end;

   modport source (output valid, output red, output green, output blue,
                   output out_column, output out_row, output row_end, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input out_column, input out_row, input row_end, output ready);
endinterface

// ----- hdl/png_scanline_unfilter_rgb8.sv -----
// A pixel appears on rsp in the cycle after its blue byte is accepted.
// Throughput: one stream byte per cycle; a blue byte waits only while an
// earlier pixel still sits undelivered in the output register.
// The prior-row memory is read every cycle of a row at the column the next
// blue byte will use, and written on the blue byte.
// Reset (synchronous) clears control and filter state and the configuration; the
// output payload and prior-row memory are not cleared; the first row never reads the memory.
module png_scanline_unfilter_rgb8 (
   input  logic                             clock,
   input  logic                             reset,
   psu_req_if.sink                          req_if,
   psu_rsp_if.source                        rsp_if,
   input  logic                             csr_write,
   input  logic [psu_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [psu_pkg::WID_BITS-1:0]     csr_wdata
);

   // Configuration registers
   logic [psu_pkg::WID_BITS-1:0] width_ff, width_in;
   logic                         alpha_ff;
   logic                         half_ff;

   // Filter state
   logic [psu_pkg::PIX_BITS-1:0] left_ff, left_in;
   logic [psu_pkg::PIX_BITS-1:0] upleft_ff, upleft_in;
   logic [psu_pkg::WID_BITS-1:0] col_ff, col_in;
   logic [psu_pkg::ROW_BITS-1:0] row_ff, row_in;
   logic                         await_ff, await_in;
   logic [2:0]                   filter_ff, filter_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [15:0]                  held_ff, held_in;

   // Prior-row memory
   logic [psu_pkg::PIX_BITS-1:0] mem [psu_pkg::MAX_WIDTH];
   logic [psu_pkg::PIX_BITS-1:0] rd_data_ff;

   // Output register
   logic                         out_valid_ff, out_valid_in;
   logic [7:0]                   out_red_ff, out_green_ff, out_blue_ff;
   logic [psu_pkg::COL_BITS-1:0] out_col_ff;
   logic [psu_pkg::ROW_BITS-1:0] out_row_ff;
   logic                         out_end_ff;

   logic [psu_pkg::WID_BITS-1:0] eff_w;
   logic [psu_pkg::WID_BITS-1:0] eff_w_next;
   logic [psu_pkg::WID_BITS-1:0] half_w;
   logic [psu_pkg::WID_BITS-1:0] col;
   logic [psu_pkg::WID_BITS-1:0] rd_col;
   logic [psu_pkg::WID_BITS-1:0] col_next;
   logic [psu_pkg::WID_BITS-1:0] col_half;
   logic [psu_pkg::COL_BITS-1:0] addr;
   logic [psu_pkg::COL_BITS-1:0] rd_addr;
   logic                         accept;
   logic                         is_blue;
   logic                         rd_en;
   logic                         wr_en;
   logic [psu_pkg::PIX_BITS-1:0] pa, pb, pc, res;
   logic [7:0]                   raw [3];
   logic                         emit, last;
   logic [psu_pkg::COL_BITS-1:0] emit_col;
   logic [psu_pkg::ROW_BITS-1:0] emit_row;

   // Clamp width and current column
   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) eff_w = psu_pkg::WID_BITS'(1);
      else if (width_ff > psu_pkg::WID_BITS'(psu_pkg::MAX_WIDTH))
         eff_w = psu_pkg::WID_BITS'(psu_pkg::MAX_WIDTH);
      half_w   = eff_w >> 1;
      col      = (col_ff >= eff_w) ? (eff_w - psu_pkg::WID_BITS'(1)) : col_ff;
      col_next = col + psu_pkg::WID_BITS'(1);
      col_half = col >> 1;
      addr     = col[psu_pkg::COL_BITS-1:0];
   end

   // Read column from the width in effect after this edge
   always_comb begin
      width_in = width_ff;
      if (csr_write && (csr_index == psu_pkg::CSR_IMAGE_WIDTH)) width_in = csr_wdata;
      eff_w_next = width_in;
      if (width_in == '0) eff_w_next = psu_pkg::WID_BITS'(1);
      else if (width_in > psu_pkg::WID_BITS'(psu_pkg::MAX_WIDTH))
         eff_w_next = psu_pkg::WID_BITS'(psu_pkg::MAX_WIDTH);
      rd_col  = (col_ff >= eff_w_next) ? (eff_w_next - psu_pkg::WID_BITS'(1)) : col_ff;
      rd_addr = rd_col[psu_pkg::COL_BITS-1:0];
   end

   // Stall only a blue byte that would overwrite an undelivered pixel
   assign is_blue      = !await_ff && (phase_ff == psu_pkg::PH_BLUE);
   assign req_if.ready = !(is_blue && out_valid_ff && !rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign rd_en        = !await_ff;
   assign wr_en        = accept && is_blue;

   // Reconstruct the pixel from left, above and above-left neighbors
   always_comb begin
      pa     = (col != '0) ? left_ff : '0;
      pb     = (row_ff != '0) ? rd_data_ff : '0;
      pc     = ((col != '0) && (row_ff != '0)) ? upleft_ff : '0;
      raw[0] = held_ff[7:0];
      raw[1] = held_ff[15:8];
      raw[2] = req_if.stream_byte;
      for (int k = 0; k < 3; k++) begin
         res[16-8*k +: 8] = raw[k] + psu_pkg::predict(filter_ff, pa[16-8*k +: 8],
                                                      pb[16-8*k +: 8], pc[16-8*k +: 8]);
      end
   end

   // Emit decision and output coordinates
   always_comb begin
      if (half_ff) begin
         emit     = !row_ff[0] && !col[0] && (col_half < half_w);
         last     = emit && ((col_half + psu_pkg::WID_BITS'(1)) == half_w);
         emit_col = col_half[psu_pkg::COL_BITS-1:0];
         emit_row = row_ff >> 1;
      end else begin
         emit     = 1'b1;
         last     = (col_next == eff_w);
         emit_col = col[psu_pkg::COL_BITS-1:0];
         emit_row = row_ff;
      end
   end

   // Advance the byte sequencer
   always_comb begin
      left_in   = left_ff;
      upleft_in = upleft_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      await_in  = await_ff;
      filter_in = filter_ff;
      phase_in  = phase_ff;
      held_in   = held_ff;
      if (accept) begin
         if (phase_ff == psu_pkg::PH_ALPHA) begin
            phase_in = psu_pkg::PH_RED;
         end else if (await_ff) begin
            filter_in = (req_if.stream_byte > 8'd4) ? psu_pkg::FILT_NONE
                                                    : req_if.stream_byte[2:0];
            await_in  = 1'b0;
            phase_in  = psu_pkg::PH_RED;
         end else if (phase_ff == psu_pkg::PH_RED) begin
            held_in[7:0] = req_if.stream_byte;
            phase_in     = psu_pkg::PH_GREEN;
         end else if (phase_ff == psu_pkg::PH_GREEN) begin
            held_in[15:8] = req_if.stream_byte;
            phase_in      = psu_pkg::PH_BLUE;
         end else begin
            upleft_in = pb;
            left_in   = res;
            phase_in  = alpha_ff ? psu_pkg::PH_ALPHA : psu_pkg::PH_RED;
            if (col_next >= eff_w) begin
               col_in   = '0;
               row_in   = row_ff + psu_pkg::ROW_BITS'(1);
               await_in = 1'b1;
            end else begin
               col_in = col_next;
            end
         end
      end
   end

   // Hold a pixel until taken; drop it once delivered
   always_comb begin
      out_valid_in = out_valid_ff;
      if (wr_en && emit) out_valid_in = 1'b1;
      else if (rsp_if.ready) out_valid_in = 1'b0;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= psu_pkg::WID_BITS'(1);
         alpha_ff     <= 1'b0;
         half_ff      <= 1'b0;
         left_ff      <= '0;
         upleft_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         await_ff     <= 1'b1;
         filter_ff    <= psu_pkg::FILT_NONE;
         phase_ff     <= psu_pkg::PH_RED;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               psu_pkg::CSR_IMAGE_WIDTH:   width_ff <= csr_wdata;
               psu_pkg::CSR_ALPHA_PRESENT: alpha_ff <= csr_wdata[0];
               psu_pkg::CSR_HALF_SIZE:     half_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         await_ff     <= await_in;
         filter_ff    <= filter_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Prior-row memory: read ahead every cycle of a row, write back on blue
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= res;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (wr_en && emit) begin
         out_red_ff   <= res[23:16];
         out_green_ff <= res[15:8];
         out_blue_ff  <= res[7:0];
         out_col_ff   <= emit_col;
         out_row_ff   <= emit_row;
         out_end_ff   <= last;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.red        = out_red_ff;
   assign rsp_if.green      = out_green_ff;
   assign rsp_if.blue       = out_blue_ff;
   assign rsp_if.out_column = out_col_ff;
   assign rsp_if.out_row    = out_row_ff;
   assign rsp_if.row_end    = out_end_ff;

endmodule

// ----- hdl/psu_checker.sv -----
`include "png_scanline_unfilter_rgb8_macros.svh"

module psu_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [7:0]                   rsp_red,
   input logic [7:0]                   rsp_green,
   input logic [7:0]                   rsp_blue,
   input logic [psu_pkg::COL_BITS-1:0] rsp_out_column,
   input logic [psu_pkg::ROW_BITS-1:0] rsp_out_row,
   input logic                         rsp_row_end
);

   logic [24+psu_pkg::COL_BITS+psu_pkg::ROW_BITS:0] rsp_payload;

   assign rsp_payload = {rsp_red, rsp_green, rsp_blue, rsp_out_column, rsp_out_row,
                         rsp_row_end};

   // A stalled pixel stays offered
   `PSU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled pixel keeps its payload
   `PSU_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload))

   // Input backpressure only comes from a blocked output
   `PSU_ASSERT_SAME(a_stall_cause, !req_ready, rsp_valid && !rsp_ready)

   // A new pixel follows an accepted byte
   `PSU_ASSERT_SAME(a_rsp_source, $rose(rsp_valid), $past(req_valid && req_ready))

endmodule

bind png_scanline_unfilter_rgb8 psu_checker u_psu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_red        (rsp_if.red),
   .rsp_green      (rsp_if.green),
   .rsp_blue       (rsp_if.blue),
   .rsp_out_column (rsp_if.out_column),
   .rsp_out_row    (rsp_if.out_row),
   .rsp_row_end    (rsp_if.row_end)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import psu_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 1800;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned HOLD_AFTER     = 150;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned CYCLE_LIMIT    = 8_000_000;
   localparam int unsigned DIRECTED_STEPS = 33;

   typedef struct packed {
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic [COL_BITS-1:0] column;
      logic [ROW_BITS-1:0] row;
      logic                row_end;
   } pixel_t;

   typedef enum logic [1:0] {STEP_BYTE, STEP_REG, STEP_FILL_ROW} step_kind_e;

   typedef struct packed {
      step_kind_e               kind;
      logic [7:0]               data;
      logic [CSR_IDX_BITS-1:0]  reg_idx;
      logic [WID_BITS-1:0]      reg_val;
      logic                     typed;
      pixel_t                   want;
   } step_t;

   localparam pixel_t NO_PIXEL = '0;

   logic                    clock;
   logic                    reset;
   logic                    csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [WID_BITS-1:0]     csr_wdata;

   psu_req_if req_ch ();
   psu_rsp_if rsp_ch ();

   png_scanline_unfilter_rgb8 u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the unfilter state and registers
   logic [PIX_BITS-1:0] above_row [MAX_WIDTH];
   logic [PIX_BITS-1:0] left_px;
   logic [PIX_BITS-1:0] above_left_px;
   logic [WID_BITS-1:0] cur_col;
   logic [ROW_BITS-1:0] cur_row;
   logic                want_filter;
   logic [2:0]          row_filter;
   logic [1:0]          byte_pos;
   logic [15:0]         held_rg;
   logic [WID_BITS-1:0] cfg_width;
   logic                cfg_alpha;
   logic                cfg_half;
   int unsigned         written_top;

   pixel_t      pixels_due [$];
   step_t       plan [DIRECTED_STEPS];
   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned pixels_checked;
   int unsigned bytes_accepted;
   int unsigned random_items;
   int unsigned rows_started;
   bit          no_gaps;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Pixels per row that the block uses for a width register value
   function automatic int unsigned used_width(input logic [WID_BITS-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_WIDTH) return MAX_WIDTH;
      return int'(v);
   endfunction

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      int da;
      int db;
      int dc;
      da = int'(b) - int'(c);
      db = int'(a) - int'(c);
      dc = int'(a) + int'(b) - 2 * int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   // Advance the shadow state by one stream byte; returns 1 when a pixel is emitted
   function automatic bit unfilter_byte(input logic [7:0] b, output pixel_t px);
      int unsigned         w;
      int unsigned         col;
      int unsigned         hw;
      logic [PIX_BITS-1:0] a;
      logic [PIX_BITS-1:0] up;
      logic [PIX_BITS-1:0] ul;
      logic [PIX_BITS-1:0] res;
      logic [7:0]          raw;
      logic [7:0]          ca;
      logic [7:0]          cb;
      logic [7:0]          cc;
      logic [7:0]          guess;
      bit                  emit;
      px = NO_PIXEL;
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;

      // drop the skipped alpha byte, then take the filter byte, then red and green
      if (byte_pos == PH_ALPHA) begin
         byte_pos = PH_RED;
         return 1'b0;
      end
      if (want_filter) begin
         row_filter = (b > 8'd4) ? FILT_NONE : b[2:0];
         want_filter = 1'b0;
         byte_pos = PH_RED;
         rows_started++;
         return 1'b0;
      end
      if (byte_pos == PH_RED) begin
         held_rg[7:0] = b;
         byte_pos = PH_GREEN;
         return 1'b0;
      end
      if (byte_pos == PH_GREEN) begin
         held_rg[15:8] = b;
         byte_pos = PH_BLUE;
         return 1'b0;
      end

      // blue byte: rebuild the pixel from its neighbors
      col = cur_col;
      if (col >= w) col = w - 1;
      a  = (col > 0) ? left_px : '0;
      up = (cur_row != 0) ? above_row[col] : '0;
      ul = (col > 0 && cur_row != 0) ? above_left_px : '0;
      for (int k = 0; k < 3; k++) begin
         raw = (k == 0) ? held_rg[7:0] : (k == 1) ? held_rg[15:8] : b;
         ca = a[23-8*k -: 8];
         cb = up[23-8*k -: 8];
         cc = ul[23-8*k -: 8];
         case (row_filter)
            FILT_SUB:     guess = ca;
            FILT_UP:      guess = cb;
            FILT_AVERAGE: guess = 8'((int'(ca) + int'(cb)) >> 1);
            FILT_PAETH:   guess = paeth_pick(ca, cb, cc);
            default:      guess = 8'd0;
         endcase
         res[23-8*k -: 8] = raw + guess;
      end
      above_left_px = up;
      above_row[col] = res;
      if (col >= written_top) written_top = col + 1;
      left_px = res;

      px.red   = res[23:16];
      px.green = res[15:8];
      px.blue  = res[7:0];
      if (cfg_half) begin
         hw = w >> 1;
         emit = !cur_row[0] && (col % 2 == 0) && ((col >> 1) < hw);
         px.row_end = emit && ((col >> 1) + 1 == hw);
         px.column  = COL_BITS'(col >> 1);
         px.row     = cur_row >> 1;
      end else begin
         emit = 1'b1;
         px.row_end = (col + 1 == w);
         px.column  = COL_BITS'(col);
         px.row     = cur_row;
      end

      byte_pos = cfg_alpha ? PH_ALPHA : PH_RED;
      if (col + 1 >= w) begin
         cur_col = '0;
         cur_row = cur_row + 1'b1;
         want_filter = 1'b1;
      end else begin
         cur_col = WID_BITS'(col + 1);
      end
      return emit;
   endfunction

   // Offer one byte after a random gap and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic typed, input pixel_t want);
      int unsigned gap;
      pixel_t      px;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.stream_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_accepted++;
      if (unfilter_byte(b, px) || typed) pixels_due.push_back(typed ? want : px);
   endtask

   // Stop offering and let every pending pixel drain
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Caller lowers csr_write after the last register of a group
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [WID_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_width = val;
         CSR_ALPHA_PRESENT: cfg_alpha = val[0];
         CSR_HALF_SIZE:     cfg_half = val[0];
         default: ;
      endcase
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d pixels still due", cycle_count,
               pixels_due.size());
      $display("TB_ERROR");
      $finish;
   end

   // Pixel receiver: random stalls, one long hold-off to back up the input
   initial begin : drain_pixels
      int unsigned stall;
      int unsigned burst;
      bit          held_off;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && pixels_checked >= HOLD_AFTER) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end
         stall = no_gaps ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         burst = $urandom_range(1, 24);
         repeat (burst) @(posedge clock);
      end
   end

   // Compare each delivered pixel with the oldest one due
   always @(posedge clock) begin : check_pixels
      pixel_t due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pixels_due.size() == 0) begin
            $error("pixel with nothing due: col %0d row %0d", rsp_ch.out_column,
                   rsp_ch.out_row);
            fail_count++;
         end else begin
            due = pixels_due.pop_front();
            pixels_checked++;
            if (rsp_ch.red !== due.red) begin
               $error("red: expected %0h, got %0h", due.red, rsp_ch.red);
               fail_count++;
            end
            if (rsp_ch.green !== due.green) begin
               $error("green: expected %0h, got %0h", due.green, rsp_ch.green);
               fail_count++;
            end
            if (rsp_ch.blue !== due.blue) begin
               $error("blue: expected %0h, got %0h", due.blue, rsp_ch.blue);
               fail_count++;
            end
            if (rsp_ch.out_column !== due.column) begin
               $error("out_column: expected %0d, got %0d", due.column, rsp_ch.out_column);
               fail_count++;
            end
            if (rsp_ch.out_row !== due.row) begin
               $error("out_row: expected %0d, got %0d", due.row, rsp_ch.out_row);
               fail_count++;
            end
            if (rsp_ch.row_end !== due.row_end) begin
               $error("row_end: expected %0b, got %0b", due.row_end, rsp_ch.row_end);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned         phase_no;
      int unsigned         n;
      int unsigned         r;
      logic [7:0]          b;
      logic [WID_BITS-1:0] w;
      logic                a;
      logic                h;
      logic                ignored;

      // Directed rows. The first row is two pixels wide, so every stored
      // entry that a later directed row reads is written first.
      plan = '{
         '{STEP_REG,      8'h00, CSR_IMAGE_WIDTH, 13'd2, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'hff, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'hff, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h00, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h01, CSR_IMAGE_WIDTH, '0, 1'b1,
           '{8'hff, 8'h00, 8'h01, 12'd0, 16'd0, 1'b0}},
         '{STEP_FILL_ROW, 8'h00, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_REG,      8'h00, CSR_IMAGE_WIDTH, 13'd0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'(FILT_SUB), CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h10, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h20, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h30, CSR_IMAGE_WIDTH, '0, 1'b1,
           '{8'h10, 8'h20, 8'h30, 12'd0, 16'd1, 1'b1}},
         '{STEP_REG,      8'h00, CSR_IMAGE_WIDTH, 13'd2, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'(FILT_UP), CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h00, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h00, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h00, CSR_IMAGE_WIDTH, '0, 1'b1,
           '{8'h10, 8'h20, 8'h30, 12'd0, 16'd2, 1'b0}},
         '{STEP_BYTE,     8'h80, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h7f, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'hff, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'(FILT_AVERAGE), CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'hff, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h01, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h80, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h00, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'hfe, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h7f, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'(FILT_PAETH), CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h55, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'haa, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'h00, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'hff, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'hff, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL},
         '{STEP_BYTE,     8'hff, CSR_IMAGE_WIDTH, '0, 1'b0, NO_PIXEL}
      };

      // Known levels from time zero, shadow state at its reset values
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.stream_byte <= 8'h00;
      csr_write <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= '0;
      for (int i = 0; i < MAX_WIDTH; i++) above_row[i] = '0;
      left_px = '0;
      above_left_px = '0;
      cur_col = '0;
      cur_row = '0;
      want_filter = 1'b1;
      row_filter = FILT_NONE;
      byte_pos = PH_RED;
      held_rg = '0;
      cfg_width = 13'd1;
      cfg_alpha = 1'b0;
      cfg_half = 1'b0;
      written_top = 0;
      fail_count = 0;
      pixels_checked = 0;
      bytes_accepted = 0;
      random_items = 0;
      rows_started = 0;
      no_gaps = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (plan[i]) begin
         case (plan[i].kind)
            STEP_REG: begin
               wait_idle();
               write_reg(plan[i].reg_idx, plan[i].reg_val);
               csr_write <= 1'b0;
            end
            STEP_BYTE: send_byte(plan[i].data, plan[i].typed, plan[i].want);
            default: begin
               no_gaps = 1'b1;
               while (!want_filter) send_byte(8'($urandom), 1'b0, NO_PIXEL);
               no_gaps = 1'b0;
            end
         endcase
      end

      // Random phases; each ends at an arbitrary byte, so width and alpha
      // changes land mid-row and mid-pixel
      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         case (phase_no)
            0: w = 13'd4096;
            1: w = 13'd1;
            2: w = 13'd4097;
            default: begin
               r = $urandom_range(0, 99);
               if (r < 3) w = 13'd0;
               else if (r < 70) w = WID_BITS'($urandom_range(1, 8));
               else if (r < 90) w = WID_BITS'($urandom_range(9, 40));
               else w = WID_BITS'($urandom_range(41, 8191));
            end
         endcase
         // keep a row that predicts from above within the stored entries
         if (!want_filter && cur_row != 0 && used_width(w) > written_top &&
             (row_filter == FILT_UP || row_filter == FILT_AVERAGE ||
              row_filter == FILT_PAETH))
            w = WID_BITS'(written_top);
         a = (phase_no < 4) ? phase_no[0] : 1'($urandom_range(0, 1));
         h = (phase_no < 4) ? phase_no[1] : 1'($urandom_range(0, 1));
         write_reg(CSR_IMAGE_WIDTH, w);
         write_reg(CSR_ALPHA_PRESENT, WID_BITS'(a));
         write_reg(CSR_HALF_SIZE, WID_BITS'(h));
         csr_write <= 1'b0;
         no_gaps = (phase_no % 4 == 3);
         n = $urandom_range(60, 240);
         for (int k = 0; k < n; k++) begin
            ignored = (byte_pos == PH_ALPHA);
            if (ignored) begin
               b = 8'($urandom);
            end else if (want_filter) begin
               if ($urandom_range(0, 99) < 85) b = 8'($urandom_range(0, 4));
               else b = 8'($urandom_range(5, 255));
               // a row that may run past the stored entries predicts from the left only
               if (cur_row != 0 && used_width(cfg_width) > written_top &&
                   b >= 8'(FILT_UP) && b <= 8'(FILT_PAETH))
                  b = 8'($urandom_range(0, 1));
            end else begin
               case ($urandom_range(0, 9))
                  0: b = 8'h00;
                  1: b = 8'hff;
                  default: b = 8'($urandom);
               endcase
            end
            send_byte(b, 1'b0, NO_PIXEL);
            if (!ignored) random_items++;
         end
         phase_no++;
      end
      no_gaps = 1'b0;
      wait_idle();

      $display("covered %0d stream bytes (%0d random) over %0d scanlines, %0d pixels checked",
               bytes_accepted, random_items, rows_started, pixels_checked);
      $display("%0d random settings of width, alpha and half-size after the directed rows",
               phase_no);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/psu_pkg.sv
hdl/psu_ifs.sv
hdl/png_scanline_unfilter_rgb8.sv
hdl/psu_checker.sv
tb/tb.sv
